/* hdl/cylinder_mesh_element_generator_core_macros.svh */
// assertion macros for the cylinder mesh element generator
`ifndef CYLINDER_MESH_ELEMENT_GENERATOR_CORE_MACROS_SVH
`define CYLINDER_MESH_ELEMENT_GENERATOR_CORE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CMEG_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define CMEG_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

/* hdl/cmeg_pkg.sv */
// types, constants and arithmetic helpers of the cylinder mesh element generator
package cmeg_pkg;

  localparam logic [1:0] REG_RADIUS   = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_SEGMENTS = 2'd2;

  localparam logic REQ_VERTEX   = 1'b0;
  localparam logic REQ_TRIANGLE = 1'b1;

  typedef enum logic [1:0] {
    GRP_BOT_CAP,
    GRP_BOT_RING,
    GRP_TOP_RING,
    GRP_TOP_CAP
  } grp_t;

  localparam logic [29:0] PI4_Q30 = 30'd843314857;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  localparam logic [5:0] D_SIN1 = 6'd42;
  localparam logic [5:0] D_SIN2 = 6'd20;
  localparam logic [5:0] D_SIN3 = 6'd6;
  localparam logic [5:0] D_COS1 = 6'd56;
  localparam logic [5:0] D_COS2 = 6'd30;
  localparam logic [5:0] D_COS3 = 6'd12;

  localparam logic [31:0] RECIP_SIN1 = 32'(64'h8000_0000 / D_SIN1);
  localparam logic [31:0] RECIP_SIN2 = 32'(64'h8000_0000 / D_SIN2);
  localparam logic [31:0] RECIP_SIN3 = 32'(64'h8000_0000 / D_SIN3);
  localparam logic [31:0] RECIP_COS1 = 32'(64'h8000_0000 / D_COS1);
  localparam logic [31:0] RECIP_COS2 = 32'(64'h8000_0000 / D_COS2);
  localparam logic [31:0] RECIP_COS3 = 32'(64'h8000_0000 / D_COS3);

  localparam int QUOT_W     = 30;
  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = QUOT_W / DIV_STEP;

  localparam int ST_DEC     = 1;
  localparam int ST_OCT     = 2;
  localparam int ST_NUM     = 3;
  localparam int ST_DIV0    = 4;
  localparam int ST_SQ      = ST_DIV0 + DIV_STAGES;
  localparam int ST_R1      = ST_SQ + 1;
  localparam int ST_C1      = ST_SQ + 2;
  localparam int ST_M1      = ST_SQ + 3;
  localparam int ST_R2      = ST_SQ + 4;
  localparam int ST_C2      = ST_SQ + 5;
  localparam int ST_M2      = ST_SQ + 6;
  localparam int ST_R3      = ST_SQ + 7;
  localparam int ST_C3      = ST_SQ + 8;
  localparam int ST_M3      = ST_SQ + 9;
  localparam int ST_FOLD    = ST_SQ + 10;
  localparam int ST_SCL     = ST_SQ + 11;
  localparam int ST_OUT     = ST_SQ + 12;
  localparam int NUM_STAGES = ST_OUT + 1;

  typedef struct packed {
    logic        req;
    logic        err;
    grp_t        grp;
    logic [9:0]  idx;
    logic [8:0]  col;
    logic [9:0]  ca;
    logic [9:0]  cb;
    logic [9:0]  cc;
    logic [2:0]  oct;
    logic [8:0]  m;
    logic [8:0]  drem;
    logic [29:0] dlow;
    logic [29:0] x;
    logic [29:0] x2;
    logic [30:0] ws;
    logic [30:0] wc;
    logic [62:0] ps;
    logic [62:0] pc;
    logic [14:0] magx;
    logic [14:0] magz;
    logic        negx;
    logic        negz;
    logic [30:0] prx;
    logic [30:0] prz;
    logic [16:0] o_px;
    logic [15:0] o_py;
    logic [16:0] o_pz;
    logic [15:0] o_nx;
    logic [15:0] o_ny;
    logic [15:0] o_nz;
  } item_t;

  // q1.30 product rounded half up
  function automatic logic [30:0] mulq(input logic [30:0] p, input logic [30:0] q);
    logic [62:0] full;
    full = 63'(p) * 63'(q) + (63'd1 << 29);
    return full[60:30];
  endfunction

  // quotient from reciprocal product, one correction step
  function automatic logic [30:0] dcorr(input logic [62:0] p, input logic [30:0] n,
                                        input logic [5:0] d);
    logic [31:0] q0;
    logic [31:0] r;
    q0 = p[62:31];
    r  = {1'b0, n} - 32'(q0 * 32'(d));
    if (r >= 32'(d)) begin
      q0 = q0 + 32'd1;
    end
    return q0[30:0];
  endfunction

  function automatic logic [14:0] toq14(input logic [30:0] v);
    logic [31:0] s;
    s = {1'b0, v} + 32'h0000_8000;
    return s[30:16];
  endfunction

endpackage

/* hdl/cylinder_mesh_element_generator_core.sv */
// cylinder mesh element generator: one vertex or triangle per request beat
// pipeline: 27 register stages between the request beat and its result beat
// throughput: one request per cycle unless m_tready stalls, set by the fully pipelined
//   angle divider (3 quotient bits a stage) and the sine/cosine polynomial stages
// reset: synchronous, clears all stage valids and loads radius 1.0, height 1.0, 8 segments
`include "cylinder_mesh_element_generator_core_macros.svh"

module cylinder_mesh_element_generator_core
  import cmeg_pkg::*;
#(
  parameter int MAX_SEGMENTS = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // element_index
  input  logic         s_tuser,   // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                  // corner_a, corner_b, corner_c
  output logic         m_tuser,   // error
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [15:0] radius;
  logic [15:0] height;
  logic [8:0]  segments;
  logic        cfg_bad;

  item_t stg [NUM_STAGES];
  item_t stg_next [NUM_STAGES];
  logic  vld [NUM_STAGES];
  logic  vin [NUM_STAGES];
  logic  adv [NUM_STAGES];
  item_t in_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= 16'd256;
      height   <= 16'd256;
      segments <= 9'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS:   radius   <= cfg_data;
        REG_HEIGHT:   height   <= cfg_data;
        REG_SEGMENTS: segments <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign cfg_bad = (radius == 16'd0) || (height == 16'd0) || (segments < 9'd3) ||
                   (int'(segments) > MAX_SEGMENTS);

  function automatic item_t step(input int k, input item_t a, input logic [8:0] seg,
                                 input logic [15:0] rad, input logic [15:0] hgt,
                                 input logic cerr);
    item_t       b;
    logic [11:0] ix, l1, l2, l3, l4, fan, t, colw, nn, va, vb, vc, e8, rr;
    logic [11:0] km [8];
    logic [2:0]  oc;
    logic [9:0]  rem;
    logic [29:0] lo;
    logic [14:0] s14, c14, fs, fc;
    logic [30:0] cv;
    logic [15:0] px, pz;
    logic        vert, tri_ok;
    int          i, j;
    b  = a;
    ix = 12'(a.idx);
    l1 = 12'(seg);
    l2 = l1 << 1;
    l3 = l1 + l2;
    l4 = l1 << 2;
    case (k)
      ST_DEC: begin
        b.err = cerr;
        b.grp = GRP_BOT_CAP;
        b.col = 9'd0;
        va = 12'd0;
        vb = 12'd0;
        vc = 12'd0;
        if (a.req == REQ_VERTEX) begin
          if (ix >= l4) b.err = 1'b1;
          if (ix < l1) begin
            b.col = ix[8:0];
          end else if (ix < l2) begin
            b.grp = GRP_BOT_RING;
            b.col = 9'(ix - l1);
          end else if (ix < l3) begin
            b.grp = GRP_TOP_RING;
            b.col = 9'(ix - l2);
          end else begin
            b.grp = GRP_TOP_CAP;
            b.col = 9'(ix - l3);
          end
        end else begin
          if (ix >= l4 - 12'd4) b.err = 1'b1;
          fan = l1 - 12'd2;
          if (ix < fan) begin
            va = ix + 12'd2;
            vb = ix + 12'd1;
          end else begin
            t = ix - fan;
            if (t < l2) begin
              colw = t >> 1;
              nn   = (colw + 12'd1 == l1) ? 12'd0 : colw + 12'd1;
              va   = l2 + colw;
              if (t[0]) begin
                vb = l1 + nn;
                vc = l2 + nn;
              end else begin
                vb = l1 + colw;
                vc = l1 + nn;
              end
            end else begin
              colw = t - l2 + 12'd1;
              va   = l3;
              vb   = l3 + colw;
              vc   = vb + 12'd1;
            end
          end
        end
        b.ca = va[9:0];
        b.cb = vb[9:0];
        b.cc = vc[9:0];
      end
      ST_OCT: begin
        e8    = {a.col, 3'b000};
        km[0] = 12'd0;
        for (j = 1; j < 8; j++) begin
          km[j] = km[j-1] + l1;
        end
        oc = 3'd0;
        for (j = 1; j < 8; j++) begin
          if (e8 >= km[j]) oc = 3'(j);
        end
        rr    = e8 - km[oc];
        b.oct = oc;
        b.m   = oc[0] ? 9'(l1 - rr) : rr[8:0];
      end
      ST_NUM: begin
        {b.drem, b.dlow} = 39'(PI4_Q30) * 39'(a.m) + 39'(seg[8:1]);
      end
      ST_SQ: begin
        b.x  = a.dlow;
        b.x2 = 30'(mulq({1'b0, a.dlow}, {1'b0, a.dlow}));
      end
      ST_R1: begin
        b.ws = {1'b0, a.x2} + 31'(D_SIN1 >> 1);
        b.wc = {1'b0, a.x2} + 31'(D_COS1 >> 1);
        b.ps = 63'(b.ws) * 63'(RECIP_SIN1);
        b.pc = 63'(b.wc) * 63'(RECIP_COS1);
      end
      ST_C1: begin
        b.ws = ONE_Q30 - dcorr(a.ps, a.ws, D_SIN1);
        b.wc = ONE_Q30 - dcorr(a.pc, a.wc, D_COS1);
      end
      ST_M1, ST_M2: begin
        b.ws = mulq({1'b0, a.x2}, a.ws);
        b.wc = mulq({1'b0, a.x2}, a.wc);
      end
      ST_R2: begin
        b.ws = a.ws + 31'(D_SIN2 >> 1);
        b.wc = a.wc + 31'(D_COS2 >> 1);
        b.ps = 63'(b.ws) * 63'(RECIP_SIN2);
        b.pc = 63'(b.wc) * 63'(RECIP_COS2);
      end
      ST_C2: begin
        b.ws = ONE_Q30 - dcorr(a.ps, a.ws, D_SIN2);
        b.wc = ONE_Q30 - dcorr(a.pc, a.wc, D_COS2);
      end
      ST_R3: begin
        b.ws = a.ws + 31'(D_SIN3 >> 1);
        b.wc = a.wc + 31'(D_COS3 >> 1);
        b.ps = 63'(b.ws) * 63'(RECIP_SIN3);
        b.pc = 63'(b.wc) * 63'(RECIP_COS3);
      end
      ST_C3: begin
        b.ws = ONE_Q30 - dcorr(a.ps, a.ws, D_SIN3);
        b.wc = ONE_Q30 - dcorr(a.pc, a.wc, D_COS3);
      end
      ST_M3: begin
        b.ws = mulq({1'b0, a.x}, a.ws);
        b.wc = mulq({1'b0, a.x2}, a.wc);
      end
      ST_FOLD: begin
        s14 = toq14(a.ws);
        cv  = ONE_Q30 - ((a.wc + 31'd1) >> 1);
        c14 = toq14(cv);
        fs  = a.oct[0] ? c14 : s14;
        fc  = a.oct[0] ? s14 : c14;
        case (a.oct[2:1])
          2'd0: begin
            b.magx = fs; b.negx = 1'b0; b.magz = fc; b.negz = 1'b0;
          end
          2'd1: begin
            b.magx = fc; b.negx = 1'b0; b.magz = fs; b.negz = 1'b1;
          end
          2'd2: begin
            b.magx = fs; b.negx = 1'b1; b.magz = fc; b.negz = 1'b1;
          end
          default: begin
            b.magx = fc; b.negx = 1'b1; b.magz = fs; b.negz = 1'b0;
          end
        endcase
      end
      ST_SCL: begin
        b.prx = 31'(32'(rad) * 32'(a.magx));
        b.prz = 31'(32'(rad) * 32'(a.magz));
      end
      ST_OUT: begin
        vert   = !a.err && (a.req == REQ_VERTEX);
        tri_ok = !a.err && (a.req == REQ_TRIANGLE);
        px     = 16'((32'(a.prx) + 32'd8192) >> 14);
        pz     = 16'((32'(a.prz) + 32'd8192) >> 14);
        b.o_px = 17'd0;
        b.o_py = 16'd0;
        b.o_pz = 17'd0;
        b.o_nx = 16'd0;
        b.o_ny = 16'd0;
        b.o_nz = 16'd0;
        if (vert) begin
          b.o_px = a.negx ? 17'd0 - {1'b0, px} : {1'b0, px};
          b.o_pz = a.negz ? 17'd0 - {1'b0, pz} : {1'b0, pz};
          if (a.grp == GRP_TOP_RING || a.grp == GRP_TOP_CAP) b.o_py = hgt;
          case (a.grp)
            GRP_BOT_CAP: b.o_ny = 16'hC000;
            GRP_TOP_CAP: b.o_ny = 16'h4000;
            default: begin
              b.o_nx = a.negx ? 16'd0 - {1'b0, a.magx} : {1'b0, a.magx};
              b.o_nz = a.negz ? 16'd0 - {1'b0, a.magz} : {1'b0, a.magz};
            end
          endcase
        end
        if (!tri_ok) begin
          b.ca = 10'd0;
          b.cb = 10'd0;
          b.cc = 10'd0;
        end
      end
      default: begin
        // restoring divider stages of the angle quotient
        if (k >= ST_DIV0 && k < ST_SQ) begin
          for (i = 0; i < DIV_STEP; i++) begin
            rem = {b.drem, b.dlow[QUOT_W-1]};
            lo  = {b.dlow[QUOT_W-2:0], 1'b0};
            if (rem >= {1'b0, seg}) begin
              rem   = rem - {1'b0, seg};
              lo[0] = 1'b1;
            end
            b.drem = rem[8:0];
            b.dlow = lo;
          end
        end
      end
    endcase
    return b;
  endfunction

  always_comb begin
    in_item     = '0;
    in_item.req = s_tuser;
    in_item.idx = s_tdata[9:0];
  end

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign stg_next[k] = in_item;
      assign vin[k]      = s_tvalid;
    end else begin : g_rest
      always_comb stg_next[k] = step(k, stg[k-1], segments, radius, height, cfg_bad);
      assign vin[k] = vld[k-1];
    end
    if (k == NUM_STAGES - 1) begin : g_tail
      assign adv[k] = !vld[k] || m_tready;
    end else begin : g_body
      assign adv[k] = !vld[k] || adv[k+1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv[k]) begin
        vld[k] <= vin[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  assign s_tready = adv[0];
  assign m_tvalid = vld[NUM_STAGES-1];
  assign m_tuser  = stg[NUM_STAGES-1].err;
  assign m_tdata  = {stg[NUM_STAGES-1].cc, stg[NUM_STAGES-1].cb, stg[NUM_STAGES-1].ca,
                     stg[NUM_STAGES-1].o_nz, stg[NUM_STAGES-1].o_ny, stg[NUM_STAGES-1].o_nx,
                     stg[NUM_STAGES-1].o_pz, stg[NUM_STAGES-1].o_py, stg[NUM_STAGES-1].o_px};

  `CMEG_CHECK(a_err_beat_zero, m_tvalid && m_tuser |-> m_tdata == '0, "error beat with data")
  `CMEG_CHECK(a_vertex_no_corners, m_tvalid && !stg[NUM_STAGES-1].req |-> m_tdata[127:98] == '0, "vertex beat with corners")
  `CMEG_CHECK(a_tri_distinct, m_tvalid && !m_tuser && stg[NUM_STAGES-1].req |-> m_tdata[107:98] != m_tdata[117:108] && m_tdata[117:108] != m_tdata[127:118] && m_tdata[107:98] != m_tdata[127:118], "degenerate triangle")
  `CMEG_CHECK_NEXT(a_accept_enters, s_tvalid && s_tready, vld[0], "accepted beat lost at entry")

endmodule
